// ===== hdl/cnl_pkg.sv =====
package cnl_pkg;

	localparam int unsigned OUT_W              = 37;
	localparam int unsigned OPERAND_W          = 32;
	localparam int unsigned PDATA_W            = 32;
	localparam int unsigned PADDR_W            = 3;
	localparam int unsigned ITER_CNT_W         = 5;
	localparam int unsigned LN2_W              = 32;
	localparam int unsigned SERIES_BITS        = 61;
	localparam int unsigned DEF_WIDTH          = 32;
	localparam int unsigned DEF_MAX_ITERATIONS = 31;

	localparam logic [ITER_CNT_W-1:0] RESET_ITER_CNT = 5'd31;
	localparam logic [LN2_W-1:0]      RESET_LN2      = 32'd1488522236;

	localparam logic REG_ITER_COUNT = 1'b0;
	localparam logic REG_LN2_VALUE  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NORM,
		ST_INIT,
		ST_ITER,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic norm;
		logic init;
		logic iter;
		logic finish;
	} cmd_t;

	function automatic logic [63:0] atanh_entry(int unsigned i, int unsigned width);
		logic [63:0] sum;
		logic [63:0] quo;
		logic [63:0] rem;
		int unsigned k;
		int unsigned e;
		int unsigned d;
		int unsigned shift;
		int b;
		sum = '0;
		for (k = 0; k < 32; k++) begin
			d = 2 * k + 1;
			if (i * d <= SERIES_BITS) begin
				e = SERIES_BITS - i * d;
				quo = '0;
				rem = '0;
				for (b = 63; b >= 0; b--) begin
					rem = {rem[62:0], (b == int'(e))};
					quo = {quo[62:0], 1'b0};
					if (rem >= 64'(d)) begin
						rem = rem - 64'(d);
						quo[0] = 1'b1;
					end
				end
				sum = sum + quo;
			end
		end
		shift = SERIES_BITS - (width - 1);
		return (sum + (64'd1 << (shift - 1))) >> shift;
	endfunction

endpackage

// ===== hdl/cnl_regs.sv =====
module cnl_regs import cnl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]    prdata,
	output logic                  pready,
	output logic [ITER_CNT_W-1:0] iteration_count,
	output logic [LN2_W-1:0]      ln2_value
);

	logic [ITER_CNT_W-1:0] iteration_count_q;
	logic [LN2_W-1:0]      ln2_value_q;
	logic                  wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iteration_count_q <= RESET_ITER_CNT;
			ln2_value_q       <= RESET_LN2;
		end else if (wr_en) begin
			case (paddr[2])
				REG_ITER_COUNT: iteration_count_q <= pwdata[ITER_CNT_W-1:0];
				REG_LN2_VALUE:  ln2_value_q       <= pwdata[LN2_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ITER_COUNT: prdata = PDATA_W'(iteration_count_q);
			REG_LN2_VALUE:  prdata = PDATA_W'(ln2_value_q);
			default:        prdata = '0;
		endcase
	end

	assign iteration_count = iteration_count_q;
	assign ln2_value       = ln2_value_q;

endmodule

// ===== hdl/cnl_ctrl.sv =====
module cnl_ctrl import cnl_pkg::*; #(
	parameter int unsigned WIDTH          = DEF_WIDTH,
	parameter int unsigned MAX_ITERATIONS = DEF_MAX_ITERATIONS,
	localparam int unsigned NW = $clog2(WIDTH),
	localparam int unsigned IW = $clog2(MAX_ITERATIONS + 2),
	localparam int unsigned RW = $clog2(3 * MAX_ITERATIONS + 2)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  logic [ITER_CNT_W-1:0] iteration_count,
	output cmd_t                  cmd,
	output logic [NW-1:0]         shamt,
	output logic [IW-1:0]         idx
);

	state_t         state_q;
	state_t         state_nxt;
	logic [NW-1:0]  shamt_q;
	logic [IW-1:0]  i_q;
	logic [RW-1:0]  rep_q;
	logic [IW-1:0]  cnt;
	logic           out_valid_q;
	logic           run;
	logic           out_free;
	logic           accept;

	assign cnt = (32'(iteration_count) > 32'(MAX_ITERATIONS)) ?
		IW'(MAX_ITERATIONS) : IW'(iteration_count);
	assign run      = (i_q <= cnt);
	assign out_free = !out_valid_q || !out_stall;
	assign accept   = (state_q == ST_IDLE) && in_valid;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_nxt = ST_NORM;
			ST_NORM: if (shamt_q == NW'(1)) state_nxt = ST_INIT;
			ST_INIT: state_nxt = ST_ITER;
			ST_ITER: if (!run) state_nxt = ST_DONE;
			ST_DONE: if (out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_NORM: cmd.norm   = 1'b1;
			ST_INIT: cmd.init   = 1'b1;
			ST_ITER: cmd.iter   = run;
			ST_DONE: cmd.finish = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			shamt_q     <= '0;
			i_q         <= '0;
			rep_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				shamt_q <= NW'(1) << (NW - 1);
			end else if (state_q == ST_NORM) begin
				shamt_q <= shamt_q >> 1;
			end
			if (state_q == ST_INIT) begin
				i_q   <= IW'(1);
				rep_q <= RW'(4);
			end else if (cmd.iter) begin
				if (RW'(i_q) == rep_q) begin
					rep_q <= RW'(i_q) * RW'(3) + RW'(1);
				end else begin
					i_q <= i_q + IW'(1);
				end
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign shamt     = shamt_q;
	assign idx       = i_q;
	assign out_valid = out_valid_q;

endmodule

// ===== hdl/cnl_datapath.sv =====
module cnl_datapath import cnl_pkg::*; #(
	parameter int unsigned WIDTH          = DEF_WIDTH,
	parameter int unsigned MAX_ITERATIONS = DEF_MAX_ITERATIONS,
	localparam int unsigned NW = $clog2(WIDTH),
	localparam int unsigned IW = $clog2(MAX_ITERATIONS + 2)
) (
	input  logic                 clk,
	input  cmd_t                 cmd,
	input  logic [NW-1:0]        shamt,
	input  logic [IW-1:0]        idx,
	input  logic [OPERAND_W-1:0] operand,
	input  logic [LN2_W-1:0]     ln2_value,
	output logic [OUT_W-1:0]     log_result
);

	localparam int unsigned XW = WIDTH + 4;
	localparam int unsigned ZW = OUT_W - 1;
	localparam int unsigned PW = LN2_W + NW;
	localparam int unsigned AW = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;
	localparam logic [WIDTH-1:0] ONES    = {WIDTH{1'b1}};
	localparam logic [XW-1:0]    ONE_FIX = XW'(1) << (WIDTH - 1);

	logic [ZW-1:0] atanh_rom [MAX_ITERATIONS];

	logic [WIDTH-1:0]     u_q;
	logic [NW-1:0]        n_q;
	logic signed [XW-1:0] x_q;
	logic signed [XW-1:0] y_q;
	logic [ZW-1:0]        z_q;
	logic [PW-1:0]        prod_q;
	logic [OUT_W-1:0]     log_result_q;

	logic                 norm_hit;
	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic [IW-1:0]        idx_m1;
	logic [ZW-1:0]        angle;

	for (genvar g = 0; g < MAX_ITERATIONS; g++) begin : g_rom
		assign atanh_rom[g] = ZW'(atanh_entry(g + 1, WIDTH));
	end

	assign norm_hit = (u_q != '0) && ((u_q & ~(ONES >> shamt)) == '0);
	assign xs       = x_q >>> idx;
	assign ys       = y_q >>> idx;
	assign idx_m1   = idx - IW'(1);
	assign angle    = atanh_rom[idx_m1[AW-1:0]];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			u_q <= WIDTH'(operand);
			n_q <= '0;
		end else if (cmd.norm && norm_hit) begin
			u_q <= u_q << shamt;
			n_q <= n_q + shamt;
		end
		if (cmd.init) begin
			x_q    <= XW'(u_q) + ONE_FIX;
			y_q    <= XW'(u_q) - ONE_FIX;
			z_q    <= '0;
			prod_q <= PW'(n_q) * PW'(ln2_value);
		end else if (cmd.iter) begin
			if (y_q[XW-1]) begin
				z_q <= z_q - angle;
				x_q <= x_q + ys;
				y_q <= y_q + xs;
			end else begin
				z_q <= z_q + angle;
				x_q <= x_q - ys;
				y_q <= y_q - xs;
			end
		end
		if (cmd.finish) begin
			log_result_q <= {z_q, 1'b0} - OUT_W'(prod_q);
		end
	end

	assign log_result = log_result_q;

endmodule

// ===== hdl/cordic_natural_log.sv =====
// Operation: an accepted operand is normalized (ST_NORM), x, y and z are initialized
// (ST_INIT), then ST_ITER runs the clamped iteration_count iterations plus its repeated
// indices (33 at reset, WIDTH 32), and ST_DONE writes the result once the output is free.
// It takes one transaction at a time; the single shift-add CORDIC unit runs one iteration per cycle.
// Reset: arst_n clears the controller and restores iteration_count and ln2_value;
// the atanh table is constant and needs no initialization.
module cordic_natural_log import cnl_pkg::*; #(
	parameter int unsigned WIDTH          = DEF_WIDTH,
	parameter int unsigned MAX_ITERATIONS = DEF_MAX_ITERATIONS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [OPERAND_W-1:0] operand,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [OUT_W-1:0]     log_result
);

	localparam int unsigned NW = $clog2(WIDTH);
	localparam int unsigned IW = $clog2(MAX_ITERATIONS + 2);

	logic [ITER_CNT_W-1:0] iteration_count;
	logic [LN2_W-1:0]      ln2_value;
	cmd_t                  cmd;
	logic [NW-1:0]         shamt;
	logic [IW-1:0]         idx;

	cnl_regs u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.iteration_count (iteration_count),
		.ln2_value       (ln2_value)
	);

	cnl_ctrl #(
		.WIDTH          (WIDTH),
		.MAX_ITERATIONS (MAX_ITERATIONS)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.iteration_count (iteration_count),
		.cmd             (cmd),
		.shamt           (shamt),
		.idx             (idx)
	);

	cnl_datapath #(
		.WIDTH          (WIDTH),
		.MAX_ITERATIONS (MAX_ITERATIONS)
	) u_datapath (
		.clk        (clk),
		.cmd        (cmd),
		.shamt      (shamt),
		.idx        (idx),
		.operand    (operand),
		.ln2_value  (ln2_value),
		.log_result (log_result)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a transaction is in progress");

	a_finish_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(out_valid && out_stall))
		else $error("result overwrote a stalled output");

	a_iter_count_write: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && (paddr[2] == REG_ITER_COUNT)
		|=> iteration_count == $past(pwdata[ITER_CNT_W-1:0]))
		else $error("iteration_count write lost");
`endif

endmodule

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top import cnl_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned NORM_SHIFT  = SERIES_BITS - (DEF_WIDTH - 1);

	typedef struct {
		logic [OPERAND_W-1:0] operand_in;
		logic [OUT_W-1:0]     log_value;
	} log_expect_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [PDATA_W-1:0]   pwdata = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [OPERAND_W-1:0] operand = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [OUT_W-1:0]     log_result;

	logic [63:0]           atanh_rom [DEF_MAX_ITERATIONS];
	logic [ITER_CNT_W-1:0] cfg_iter_count = RESET_ITER_CNT;
	logic [LN2_W-1:0]      cfg_ln2 = RESET_LN2;

	logic [OPERAND_W-1:0] pending_operands [$];
	log_expect_t          expected_logs [$];
	int unsigned          send_idle_pct = 0;
	int unsigned          recv_idle_pct = 0;
	int unsigned          error_count = 0;
	int unsigned          quiet_cycles = 0;

	cordic_natural_log dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operand    (operand),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.log_result (log_result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [OUT_W-1:0] predict_log(logic [OPERAND_W-1:0] value);
		logic [63:0] u, x, y, z, xs, ys, acc;
		int unsigned lz, count, idx, repeat_idx, j;
		bit found;
		lz = 0;
		found = 1'b0;
		for (j = 0; j < OPERAND_W; j++) begin
			if (!found && value[OPERAND_W-1-j]) begin
				lz = j;
				found = 1'b1;
			end
		end
		u = {32'd0, value << lz};
		x = u + 64'h8000_0000;
		y = u - 64'h8000_0000;
		z = '0;
		count = cfg_iter_count;
		if (count > DEF_MAX_ITERATIONS)
			count = DEF_MAX_ITERATIONS;
		idx = 1;
		repeat_idx = 4;
		while (idx <= count) begin
			xs = $signed(x) >>> idx;
			ys = $signed(y) >>> idx;
			if (y[63]) begin
				z -= atanh_rom[idx-1];
				x += ys;
				y += xs;
			end else begin
				z += atanh_rom[idx-1];
				x -= ys;
				y -= xs;
			end
			if (idx == repeat_idx)
				repeat_idx = 3 * idx + 1;
			else
				idx++;
		end
		acc = (z << 1) - 64'(lz) * {32'd0, cfg_ln2};
		return acc[OUT_W-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic apb_write(input logic reg_idx, input logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_idx == REG_ITER_COUNT)
			cfg_iter_count = data[ITER_CNT_W-1:0];
		else
			cfg_ln2 = data[LN2_W-1:0];
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_operands.size() != 0 || in_valid || expected_logs.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic queue_random_operands(input int unsigned count);
		logic [OPERAND_W-1:0] v;
		int unsigned sel;
		repeat (count) begin
			sel = $urandom_range(19);
			if (sel == 0)
				v = '0;
			else if (sel < 6)
				v = $urandom();
			else
				v = $urandom() >> $urandom_range(OPERAND_W - 1);
			pending_operands.push_back(v);
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_logs.push_back('{operand_in: operand, log_value: predict_log(operand)});
			if (!in_valid || !in_stall) begin
				if (pending_operands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					operand  <= pending_operands.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin : monitor
		log_expect_t head;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_logs.size() == 0) begin
					report_mismatch($sformatf("unexpected transaction log_result=%h", log_result));
				end else begin
					head = expected_logs.pop_front();
					if (log_result !== head.log_value)
						report_mismatch($sformatf("operand=%h log_result=%h want %h",
							head.operand_in, log_result, head.log_value));
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog expired with %0d results outstanding", expected_logs.size());
				$display("FAIL cordic_natural_log");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [63:0] sum;
		int unsigned i, k;
		for (i = 1; i <= DEF_MAX_ITERATIONS; i++) begin
			sum = '0;
			for (k = 0; i * (2 * k + 1) <= SERIES_BITS; k++)
				sum += (64'd1 << (SERIES_BITS - i * (2 * k + 1))) / 64'(2 * k + 1);
			atanh_rom[i-1] = (sum + (64'd1 << (NORM_SHIFT - 1))) >> NORM_SHIFT;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 10;
		recv_idle_pct = 48;
		pending_operands = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
			32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h4000_0000,
			32'hC000_0000, 32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h0001_0000, 32'h0000_FFFF, 32'hB504_F333, 32'h0000_0100};
		wait_drained();

		// no iterations: result is the shift correction alone
		apb_write(REG_ITER_COUNT, 32'd0);
		apb_write(REG_LN2_VALUE, 32'hFFFF_FFFF);
		pending_operands = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000};
		wait_drained();

		apb_write(REG_ITER_COUNT, 32'd1);
		apb_write(REG_LN2_VALUE, 32'd0);
		pending_operands = '{32'h0000_0000, 32'h0000_0003, 32'h7FFF_FFFF, 32'h8000_0000};
		wait_drained();

		apb_write(REG_ITER_COUNT, 32'd31);
		apb_write(REG_LN2_VALUE, RESET_LN2);
		queue_random_operands(160);
		wait_drained();

		send_idle_pct = 48;
		recv_idle_pct = 10;
		apb_write(REG_ITER_COUNT, 32'($urandom_range(30)));
		apb_write(REG_LN2_VALUE, $urandom());
		queue_random_operands(160);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		apb_write(REG_ITER_COUNT, 32'd31);
		apb_write(REG_LN2_VALUE, $urandom());
		queue_random_operands(130);
		wait_drained();

		repeat (50) @(posedge clk);
		if (expected_logs.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_logs.size()));
		if (error_count == 0)
			$display("PASS cordic_natural_log");
		else
			$display("FAIL cordic_natural_log");
		$finish;
	end

endmodule

`default_nettype wire
